FILE: design/access_token_table_assert.svh
// assertion macros used by the access token table top level
`ifndef ACCESS_TOKEN_TABLE_ASSERT_SVH
`define ACCESS_TOKEN_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ATT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("access_token_table: same-cycle check failed");

// next-cycle implication, checked out of reset
`define ATT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("access_token_table: next-cycle check failed");

`endif

FILE: design/att_pkg.sv
// types and constants of the access token table
`timescale 1ns / 1ps

package att_pkg;

  localparam int unsigned LABEL_W     = 64;
  localparam int unsigned ID_W        = 32;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned MAX_RES     = 16;
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_MATCH  = 2'd2,
    ACT_LIST   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_CHECK = 2'd2
  } state_t;

endpackage

FILE: design/att_cmp.sv
// key register with label/id normalization and the shared equality comparator
`timescale 1ns / 1ps

module att_cmp #(
  parameter int unsigned LABEL_CHARS = 8,
  parameter int unsigned KEY_ID_W    = 32
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic [att_pkg::LABEL_W-1:0]  in_label,
  input  logic [att_pkg::ID_W-1:0]     in_id,
  input  logic                         mode_id,
  input  logic [att_pkg::LABEL_W-1:0]  rd_label,
  input  logic [KEY_ID_W-1:0]          rd_id,
  output logic [att_pkg::LABEL_W-1:0]  key_label,
  output logic [KEY_ID_W-1:0]          key_id,
  output logic                         eq
);
  import att_pkg::*;

  logic [LABEL_W-1:0]  lab_norm;
  logic                nul_seen;
  logic [7:0]          ch;
  logic [LABEL_W-1:0]  key_label_r;
  logic [KEY_ID_W-1:0] key_id_r;
  logic [LABEL_W-1:0]  opa;
  logic [LABEL_W-1:0]  opb;

  // cut label to its chars and clear everything after the first nul
  always_comb begin
    nul_seen = 1'b0;
    lab_norm = '0;
    ch       = '0;
    for (int i = 0; i < 8; i++) begin
      ch = in_label[8*i +: 8];
      if ((i >= int'(LABEL_CHARS)) || (ch == 8'd0)) begin
        nul_seen = 1'b1;
      end
      lab_norm[8*i +: 8] = nul_seen ? 8'd0 : ch;
    end
  end

  // key register, loaded when a word is accepted
  always_ff @(posedge clk) begin
    if (load) begin
      key_label_r <= lab_norm;
      key_id_r    <= in_id[KEY_ID_W-1:0];
    end
  end

  // one comparator serves label and identifier searches
  always_comb begin
    if (mode_id) begin
      opa = {{(LABEL_W-KEY_ID_W){1'b0}}, key_id_r};
      opb = {{(LABEL_W-KEY_ID_W){1'b0}}, rd_id};
    end else begin
      opa = key_label_r;
      opb = rd_label;
    end
  end

  assign eq        = (opa == opb);
  assign key_label = key_label_r;
  assign key_id    = key_id_r;

endmodule

FILE: design/access_token_table.sv
// access token table top level: token store, slot scanner and result register
`timescale 1ns / 1ps
`include "access_token_table_assert.svh"

// Table of ENTRIES access tokens (active bit, nul-padded label, identifier),
// searched one slot at a time. Input word tdata: action [1:0], label [65:2],
// token_id [97:66]. Result word: tuser = ok, tdata = entry_label [63:0] and
// slot_index [67:64], tlast = last of the item. Each visited slot is first
// read from the single-port store into a register, then checked by the
// shared comparator: add, remove and match stop at the first hit, or after
// the last slot on a miss; list stops at the slot of its last reported entry
// (the last active one, at most the sixteenth), or after the last slot when
// no slot is active. The check of a slot stalls while the output register
// holds a result that out_tready has not yet taken. in_tready is high only
// between items; the previous result may still wait in the output register
// meanwhile.
module access_token_table #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned ID_BYTES    = 4,
  parameter int unsigned LABEL_CHARS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // action, label, token_id from bit 0 up, zero filled
  input  logic [att_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // entry_label, slot_index from bit 0 up, zero filled
  output logic [att_pkg::OUT_TDATA_W-1:0] out_tdata,
  // ok
  output logic                           out_tuser,
  output logic                           out_tlast
);
  import att_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned IdW  = 8 * ((ID_BYTES < 4) ? ID_BYTES : 4);

  state_t              state_r, state_nxt;
  act_t                act_r, act_nxt;
  logic [IdxW-1:0]     idx_r, idx_nxt;
  logic [4:0]          list_n_r, list_n_nxt;
  logic [CntW-1:0]     cnt_r;
  logic [ENTRIES-1:0]  active_r;

  logic [LABEL_W-1:0]  label_mem [ENTRIES];
  logic [IdW-1:0]      id_mem [ENTRIES];
  logic [LABEL_W-1:0]  rd_label_r;
  logic [IdW-1:0]      rd_id_r;

  logic [LABEL_W-1:0]  key_label;
  logic [IdW-1:0]      key_id;
  logic                eq;
  logic                load_key;

  logic                wr_en, act_set, act_clr;
  logic                out_load, out_free, hit, end_slot, last_list;
  logic                res_ok, res_last;
  logic [LABEL_W-1:0]  res_label;
  logic [SLOT_W-1:0]   res_slot;
  logic [IdxW+3:0]     slot_wide;
  logic [6:0]          cnt_ext;
  logic [4:0]          lim;

  logic                out_tvalid_r;
  logic                out_ok_r, out_last_r;
  logic [LABEL_W-1:0]  out_label_r;
  logic [SLOT_W-1:0]   out_slot_r;

  // shared key compare unit
  att_cmp #(
    .LABEL_CHARS (LABEL_CHARS),
    .KEY_ID_W    (IdW)
  ) u_cmp (
    .clk       (clk),
    .load      (load_key),
    .in_label  (in_tdata[65:2]),
    .in_id     (in_tdata[97:66]),
    .mode_id   (act_r == ACT_MATCH),
    .rd_label  (rd_label_r),
    .rd_id     (rd_id_r),
    .key_label (key_label),
    .key_id    (key_id),
    .eq        (eq)
  );

  // token store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      label_mem[idx_r] <= key_label;
      id_mem[idx_r]    <= key_id;
    end
    rd_label_r <= label_mem[idx_r];
    rd_id_r    <= id_mem[idx_r];
  end

  // list length: active count capped at sixteen
  assign cnt_ext   = 7'(cnt_r);
  assign lim       = (cnt_ext >= 7'(MAX_RES)) ? 5'(MAX_RES) : cnt_ext[4:0];
  assign last_list = ((list_n_r + 5'd1) == lim);
  assign end_slot  = (idx_r == IdxW'(ENTRIES - 1));
  assign out_free  = !out_tvalid_r || out_tready;
  assign slot_wide = {4'b0000, idx_r};

  // slot hit for the current action
  always_comb begin
    unique case (act_r)
      ACT_ADD:    hit = !active_r[idx_r];
      ACT_REMOVE: hit = active_r[idx_r] && eq;
      ACT_MATCH:  hit = active_r[idx_r] && eq;
      ACT_LIST:   hit = active_r[idx_r];
      default:    hit = 1'b0;
    endcase
  end

  // sequencer: accept, read slot, check slot
  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    idx_nxt    = idx_r;
    list_n_nxt = list_n_r;
    load_key   = 1'b0;
    wr_en      = 1'b0;
    act_set    = 1'b0;
    act_clr    = 1'b0;
    out_load   = 1'b0;
    res_ok     = 1'b0;
    res_label  = '0;
    res_slot   = '0;
    res_last   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          load_key   = 1'b1;
          act_nxt    = act_t'(in_tdata[1:0]);
          idx_nxt    = '0;
          list_n_nxt = '0;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (out_free) begin
          if (hit) begin
            out_load = 1'b1;
            res_ok   = 1'b1;
            res_slot = slot_wide[3:0];
            if ((act_r == ACT_MATCH) || (act_r == ACT_LIST)) begin
              res_label = rd_label_r;
            end
            wr_en   = (act_r == ACT_ADD);
            act_set = (act_r == ACT_ADD);
            act_clr = (act_r == ACT_REMOVE);
            if (act_r == ACT_LIST) begin
              res_last   = last_list;
              list_n_nxt = list_n_r + 5'd1;
              if (last_list || end_slot) begin
                state_nxt = ST_IDLE;
              end else begin
                idx_nxt   = idx_r + IdxW'(1);
                state_nxt = ST_READ;
              end
            end else begin
              state_nxt = ST_IDLE;
            end
          end else if (end_slot) begin
            // nothing found: one empty result unless a list already reported an entry
            out_load  = !((act_r == ACT_LIST) && (list_n_r != 5'd0));
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + IdxW'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      act_r    <= ACT_ADD;
      idx_r    <= '0;
      list_n_r <= '0;
      cnt_r    <= '0;
      active_r <= '0;
    end else begin
      state_r  <= state_nxt;
      act_r    <= act_nxt;
      idx_r    <= idx_nxt;
      list_n_r <= list_n_nxt;
      if (act_set) begin
        active_r[idx_r] <= 1'b1;
        cnt_r           <= cnt_r + CntW'(1);
      end else if (act_clr) begin
        active_r[idx_r] <= 1'b0;
        cnt_r           <= cnt_r - CntW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r    <= res_ok;
      out_label_r <= res_label;
      out_slot_r  <= res_slot;
      out_last_r  <= res_last;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_slot_r, out_label_r};
  assign out_tuser  = out_ok_r;
  assign out_tlast  = out_last_r;

  // checks
  `ATT_ASSERT_IMP(a_cnt_matches_active, 1'b1, cnt_r == CntW'($countones(active_r)))
  `ATT_ASSERT_IMP(a_fail_is_clean, out_tvalid_r && !out_ok_r,
                  out_label_r == '0 && out_slot_r == '0 && out_last_r)
  `ATT_ASSERT_NXT(a_accept_starts_scan, in_tvalid && in_tready, state_r == ST_READ)
  `ATT_ASSERT_NXT(a_last_ends_item, out_load && res_last, state_r == ST_IDLE)

endmodule
